[hw/rtl/ffbt_pkg.sv]
// Package for the first-fit boundary-tag allocator.
// Shared constants, field widths and the controller state type.
// No dependencies.
`default_nettype none
package ffbt_pkg;

    localparam int HEAP_BYTES_DEF = 8192;
    localparam int TAG_W          = 16;
    localparam int REQ_W          = 13;
    localparam int ADDR_W         = 14;
    localparam int STATUS_W       = 2;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SZ = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_CHK,
        S_P_RD,
        S_P_CHK,
        S_N_RD,
        S_N_CHK,
        S_WR,
        S_DONE
    } ctrl_state_t;

endpackage
`default_nettype wire

[hw/rtl/first_fit_boundary_tag_allocator.sv]
//  channel | dir | tdata bits (low to high)                  | accept
//  s_      | in  | func[0] req_size[13:1] block_addr[27:14]   | s_tvalid & s_tready
//  m_      | out | payload_addr[13:0] status[15:14]           | m_tvalid & m_tready
// Allocate: one tag read per block visited on the walk, then 4 tag writes on a fit.
// Free: one tag read per block walked up to the target, two neighbor tag reads, 2 writes.
// The walk is bound by the single tag memory read port.
// After reset a clearing pass writes all HEAP_BYTES/2+2 tag words before the first
// word is taken. One result buffer lets a new word in while the previous result waits.
// Depends on ffbt_pkg and ffbt_ram.
`default_nettype none
module first_fit_boundary_tag_allocator #(
    parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // func, req_size, block_addr, zero pad
    input  wire logic [ffbt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // payload_addr, status
    output logic      [ffbt_pkg::M_TDATA_W-1:0] m_tdata
);
    localparam int DEPTH = HEAP_BYTES / 2 + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = ($clog2(HEAP_BYTES) + 2 > 15) ? $clog2(HEAP_BYTES) + 2 : 15;
    localparam int TW    = ffbt_pkg::TAG_W;
    localparam int AD    = ffbt_pkg::ADDR_W;
    localparam int RW    = ffbt_pkg::REQ_W;
    localparam int SW    = ffbt_pkg::STATUS_W;

    localparam logic [BW-1:0] HEAP_LIM  = BW'(HEAP_BYTES);
    localparam logic [BW-1:0] FIRST_BP  = BW'(4);
    localparam logic [BW-1:0] OVERHEAD  = BW'(4);
    localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);
    localparam logic [AW-1:0] FOOT_WORD = AW'(HEAP_BYTES / 2);
    localparam logic [TW-1:0] FREE_TAG  = TW'(HEAP_BYTES - 4);

    ffbt_pkg::ctrl_state_t state_reg, state_next;

    logic [BW-1:0] bp_reg, bp_next, sz_reg, sz_next, asz_reg, asz_next;
    logic [BW-1:0] start_reg, start_next, total_reg, total_next;
    logic [AD-1:0] addr_reg, addr_next;
    logic          free_reg, free_next;
    logic [1:0]    step_reg, step_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AD-1:0] res_pay_reg, res_pay_next;
    logic [SW-1:0] res_st_reg, res_st_next;
    logic          mv_reg, mv_next;
    logic [AD-1:0] m_pay_reg, m_pay_next;
    logic [SW-1:0] m_st_reg, m_st_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [TW-1:0] wdata, rdata;
    logic [BW-1:0] wbyte, rbyte;

    logic          in_func;
    logic [RW-1:0] in_req;
    logic [AD-1:0] in_addr;
    logic [BW-1:0] t_sz, asz_in, adv, rem;
    logic          t_alloc, out_free;

    assign in_func = s_tdata[0];
    assign in_req  = s_tdata[RW:1];
    assign in_addr = s_tdata[RW+AD:RW+1];

    assign t_sz    = BW'({rdata[14:1], 1'b0});
    assign t_alloc = rdata[0];
    assign asz_in  = BW'({in_req[RW-1:1], 1'b0}) + (in_req[0] ? BW'(2) : BW'(0));
    assign adv     = bp_reg + t_sz + OVERHEAD;
    assign rem     = sz_reg - asz_reg - OVERHEAD;
    assign out_free = !mv_reg || m_tready;

    ffbt_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tags (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffbt_pkg::S_CLEAR: if (clr_reg == LAST_WORD) state_next = ffbt_pkg::S_IDLE;
            ffbt_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (in_func == ffbt_pkg::FUNC_FREE) state_next = ffbt_pkg::S_F_RD;
                    else if (in_req == '0)             state_next = ffbt_pkg::S_DONE;
                    else                               state_next = ffbt_pkg::S_A_RD;
                end
            end
            ffbt_pkg::S_A_RD: state_next = ffbt_pkg::S_A_CHK;
            ffbt_pkg::S_A_CHK: begin
                if (t_sz == '0)                                 state_next = ffbt_pkg::S_DONE;
                else if (!t_alloc && t_sz >= asz_reg + BW'(5))  state_next = ffbt_pkg::S_WR;
                else if (adv > HEAP_LIM)                        state_next = ffbt_pkg::S_DONE;
                else                                            state_next = ffbt_pkg::S_A_RD;
            end
            ffbt_pkg::S_F_RD: state_next = ffbt_pkg::S_F_CHK;
            ffbt_pkg::S_F_CHK: begin
                if (t_sz == '0)                       state_next = ffbt_pkg::S_DONE;
                else if (bp_reg == BW'(addr_reg))     state_next = t_alloc ? ffbt_pkg::S_P_RD
                                                                           : ffbt_pkg::S_DONE;
                else if (bp_reg > BW'(addr_reg))      state_next = ffbt_pkg::S_DONE;
                else if (adv > HEAP_LIM)              state_next = ffbt_pkg::S_DONE;
                else                                  state_next = ffbt_pkg::S_F_RD;
            end
            ffbt_pkg::S_P_RD:  state_next = ffbt_pkg::S_P_CHK;
            ffbt_pkg::S_P_CHK: state_next = ffbt_pkg::S_N_RD;
            ffbt_pkg::S_N_RD:  state_next = ffbt_pkg::S_N_CHK;
            ffbt_pkg::S_N_CHK: state_next = ffbt_pkg::S_WR;
            ffbt_pkg::S_WR: begin
                if (step_reg == (free_reg ? 2'd1 : 2'd3)) state_next = ffbt_pkg::S_DONE;
            end
            ffbt_pkg::S_DONE: if (out_free) state_next = ffbt_pkg::S_IDLE;
            default: state_next = ffbt_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        bp_next      = bp_reg;
        sz_next      = sz_reg;
        asz_next     = asz_reg;
        start_next   = start_reg;
        total_next   = total_reg;
        addr_next    = addr_reg;
        free_next    = free_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        res_pay_next = res_pay_reg;
        res_st_next  = res_st_reg;
        mv_next      = mv_reg && !m_tready;
        m_pay_next   = m_pay_reg;
        m_st_next    = m_st_reg;
        s_tready     = 1'b0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        wbyte        = '0;
        rbyte        = '0;
        case (state_reg)
            ffbt_pkg::S_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == '0 || clr_reg == LAST_WORD)           wdata = TW'(1);
                else if (clr_reg == AW'(1) || clr_reg == FOOT_WORD)  wdata = FREE_TAG;
                else                                                 wdata = '0;
                clr_next = clr_reg + AW'(1);
            end
            ffbt_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    bp_next      = FIRST_BP;
                    asz_next     = asz_in;
                    addr_next    = in_addr;
                    free_next    = in_func;
                    step_next    = '0;
                    res_pay_next = '0;
                    res_st_next  = (in_func == ffbt_pkg::FUNC_ALLOC && in_req == '0)
                                 ? ffbt_pkg::ST_ZERO_SZ : ffbt_pkg::ST_OK;
                end
            end
            ffbt_pkg::S_A_RD, ffbt_pkg::S_F_RD: rbyte = bp_reg - BW'(2);
            ffbt_pkg::S_A_CHK: begin
                sz_next = t_sz;
                bp_next = adv;
                if (t_sz == '0 || ((t_alloc || t_sz < asz_reg + BW'(5)) && adv > HEAP_LIM)) begin
                    res_st_next = ffbt_pkg::ST_NO_FIT;
                end
                if (t_sz != '0 && !t_alloc && t_sz >= asz_reg + BW'(5)) begin
                    bp_next      = bp_reg;
                    res_pay_next = AD'(bp_reg);
                end
            end
            ffbt_pkg::S_F_CHK: begin
                sz_next    = t_sz;
                start_next = bp_reg;
                total_next = t_sz;
                if (!(bp_reg == BW'(addr_reg) || bp_reg > BW'(addr_reg))) bp_next = adv;
            end
            ffbt_pkg::S_P_RD: rbyte = bp_reg - BW'(4);
            ffbt_pkg::S_P_CHK: begin
                if (t_sz != '0 && !t_alloc) begin
                    start_next = bp_reg - t_sz - OVERHEAD;
                    total_next = total_reg + t_sz + OVERHEAD;
                end
            end
            ffbt_pkg::S_N_RD: rbyte = bp_reg + sz_reg + BW'(2);
            ffbt_pkg::S_N_CHK: begin
                if (t_sz != '0 && !t_alloc) total_next = total_reg + t_sz + OVERHEAD;
            end
            ffbt_pkg::S_WR: begin
                we        = 1'b1;
                step_next = step_reg + 2'd1;
                if (free_reg) begin
                    wbyte = (step_reg == 2'd0) ? start_reg - BW'(2) : start_reg + total_reg;
                    wdata = TW'(total_reg);
                end else begin
                    case (step_reg)
                        2'd0:    begin wbyte = bp_reg - BW'(2);       wdata = TW'(asz_reg) | TW'(1); end
                        2'd1:    begin wbyte = bp_reg + asz_reg;      wdata = TW'(asz_reg) | TW'(1); end
                        2'd2:    begin wbyte = bp_reg + asz_reg + BW'(2); wdata = TW'(rem);      end
                        default: begin wbyte = bp_reg + sz_reg;       wdata = TW'(rem);              end
                    endcase
                end
                waddr = wbyte[AW:1];
            end
            ffbt_pkg::S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    m_pay_next = res_pay_reg;
                    m_st_next  = res_st_reg;
                end
            end
            default: ;
        endcase
        raddr = rbyte[AW:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffbt_pkg::S_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        bp_reg      <= bp_next;
        sz_reg      <= sz_next;
        asz_reg     <= asz_next;
        start_reg   <= start_next;
        total_reg   <= total_next;
        addr_reg    <= addr_next;
        free_reg    <= free_next;
        res_pay_reg <= res_pay_next;
        res_st_reg  <= res_st_next;
        m_pay_reg   <= m_pay_next;
        m_st_reg    <= m_st_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {m_st_reg, m_pay_reg};
endmodule
`default_nettype wire

[hw/rtl/ffbt_ram.sv]
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ffbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4098
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/ffbt_checker.sv]
// Port-level checks for the allocator, bound to the top level.
// Depends on first_fit_boundary_tag_allocator.
`default_nettype none
module ffbt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] != 2'd3)
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15:14] != 2'd0 |-> m_tdata[13:0] == 14'd0)
        else $error("error result carries an address");

    a_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == 1'b0)
        else $error("odd payload address");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken during a walk");
endmodule

bind first_fit_boundary_tag_allocator ffbt_checker u_ffbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[tb/sv/ffbt_checker.sv]
// Checker for the first-fit boundary-tag allocator: watches both streams,
// predicts each result word from its own heap image and compares field by field.
// Depends on ffbt_pkg.
`timescale 1ns / 100ps
`default_nettype none
module ffbt_scoreboard #(
    parameter int HEAP_BYTES = ffbt_pkg::HEAP_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);
    localparam int WORDS = HEAP_BYTES / 2 + 2;

    typedef struct packed {
        logic [ffbt_pkg::STATUS_W-1:0] status;
        logic [ffbt_pkg::ADDR_W-1:0]   payload_addr;
    } heap_result_t;

    logic [15:0]  heap_tags [WORDS];
    heap_result_t expected_results [$];

    function automatic int tag_at(int addr);
        int i;
        i = addr >> 1;
        if (i < 0 || i >= WORDS) return 1;
        return int'(heap_tags[i]);
    endfunction

    function automatic void put_tag(int addr, int v);
        int i;
        i = addr >> 1;
        if (i >= 0 && i < WORDS) heap_tags[i] = v[15:0];
    endfunction

    function automatic void mark_block(int bp, int size, int alloc);
        put_tag(bp - 2, size | alloc);
        put_tag(bp + size, size | alloc);
    endfunction

    function automatic void heap_init();
        foreach (heap_tags[i]) heap_tags[i] = '0;
        put_tag(0, 1);
        mark_block(4, HEAP_BYTES - 4, 0);
        put_tag(HEAP_BYTES + 2, 1);
    endfunction

    function automatic heap_result_t heap_alloc(int req);
        heap_result_t r;
        int asz, bp, t, sz;
        r = '0;
        asz = (req + 1) & ~1;
        bp = 4;
        r.status = ffbt_pkg::ST_NO_FIT;
        while (bp <= HEAP_BYTES) begin
            t = tag_at(bp - 2);
            sz = t & ~1;
            if (sz == 0) break;
            if ((t & 1) == 0 && sz >= asz + 5) begin
                mark_block(bp, asz, 1);
                mark_block(bp + asz + 4, sz - asz - 4, 0);
                r.status = ffbt_pkg::ST_OK;
                r.payload_addr = bp[ffbt_pkg::ADDR_W-1:0];
                break;
            end
            bp += sz + 4;
        end
        return r;
    endfunction

    function automatic void heap_dealloc(int addr);
        int bp, t, sz, start, total, pt, psz, nt, nsz;
        bit found;
        bp = 4;
        found = 0;
        while (bp <= HEAP_BYTES) begin
            t = tag_at(bp - 2);
            sz = t & ~1;
            if (sz == 0) break;
            if (bp == addr) begin
                found = (t & 1) != 0;
                break;
            end
            if (bp > addr) break;
            bp += sz + 4;
        end
        if (!found) return;
        sz = tag_at(bp - 2) & ~1;
        start = bp;
        total = sz;
        pt = tag_at(bp - 4);
        psz = pt & ~1;
        if (psz != 0 && (pt & 1) == 0) begin
            start = bp - psz - 4;
            total += psz + 4;
        end
        nt = tag_at(bp + sz + 2);
        nsz = nt & ~1;
        if (nsz != 0 && (nt & 1) == 0) total += nsz + 4;
        mark_block(start, total, 0);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        heap_result_t e, g;
        if (!aresetn) begin
            heap_init();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                e = '0;
                if (s_tdata[0] == ffbt_pkg::FUNC_ALLOC) begin
                    if (s_tdata[13:1] == 0) e.status = ffbt_pkg::ST_ZERO_SZ;
                    else e = heap_alloc(int'(s_tdata[13:1]));
                end else begin
                    heap_dealloc(int'(s_tdata[27:14]));
                end
                expected_results.push_back(e);
            end
            if (m_tvalid && m_tready) begin
                g = m_tdata;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_tdata), -1);
                end else begin
                    e = expected_results.pop_front();
                    if (g.payload_addr !== e.payload_addr)
                        report_mismatch("payload_addr", int'(g.payload_addr),
                                        int'(e.payload_addr));
                    if (g.status !== e.status)
                        report_mismatch("status", int'(g.status), int'(e.status));
                end
            end
        end
        pending <= expected_results.size();
    end

    initial begin
        fail_count = 0;
        results_seen = 0;
        pending = 0;
    end
endmodule
`default_nettype wire

[tb/sv/first_fit_boundary_tag_allocator_test.sv]
// Top of the allocator test: clock, reset, allocate/free stimulus, stalls
// and verdict. Depends on ffbt_pkg, ffbt_scoreboard and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_boundary_tag_allocator_test;
    localparam int HEAP = ffbt_pkg::HEAP_BYTES_DEF;
    localparam int IDLE_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 800;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    int          fail_count, pending, results_seen;
    bit          quiet_tail = 0;
    bit          hold_sink = 0;
    int          idle_cycles = 0;
    int          live_blocks [$];

    first_fit_boundary_tag_allocator #(.HEAP_BYTES(HEAP)) u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    ffbt_scoreboard #(.HEAP_BYTES(HEAP)) u_check (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .pending, .results_seen
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver: random stall bursts, a long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 14);
                m_tready <= 0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(bit func, int req, int addr);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 14);
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'b0, addr[13:0], req[12:0], func};
        do @(posedge aclk); while (!s_tready);
        if (func == ffbt_pkg::FUNC_FREE) begin
            foreach (live_blocks[i]) if (live_blocks[i] == addr) begin
                live_blocks.delete(i);
                break;
            end
        end
    endtask

    // note each returned payload offset for later frees
    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tdata[15:14] == ffbt_pkg::ST_OK && m_tdata[13:0] != 0)
            live_blocks.push_back(int'(m_tdata[13:0]));

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        int k, a;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        // directed
        send_word(ffbt_pkg::FUNC_ALLOC, 0, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 1, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 8188, 16383);
        send_word(ffbt_pkg::FUNC_ALLOC, 8191, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 2, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 7, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 5, 0);
        send_word(ffbt_pkg::FUNC_FREE, 0, 3);
        send_word(ffbt_pkg::FUNC_FREE, 0, 16383);
        send_word(ffbt_pkg::FUNC_FREE, 0, 6);
        drain();
        send_word(ffbt_pkg::FUNC_FREE, 8191, 8);
        send_word(ffbt_pkg::FUNC_FREE, 8191, 8);
        drain();
        while (live_blocks.size() > 0) send_word(ffbt_pkg::FUNC_FREE, 0, live_blocks[0]);
        send_word(ffbt_pkg::FUNC_ALLOC, 8180, 0);
        send_word(ffbt_pkg::FUNC_ALLOC, 100, 0);
        drain();
        while (live_blocks.size() > 0) send_word(ffbt_pkg::FUNC_FREE, 0, live_blocks[0]);
        drain();
        // long receiver hold-off while words keep coming
        hold_sink = 1;
        for (k = 0; k < 12; k++) send_word(ffbt_pkg::FUNC_ALLOC, $urandom_range(1, 60), 0);
        drain();
        // random mix of allocations, valid frees of live blocks and bogus frees
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k > RANDOM_ITEMS - 120) quiet_tail = 1;
            if (k % 40 == 39) drain();
            a = $urandom_range(0, 99);
            if (a < 45) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(ffbt_pkg::FUNC_ALLOC, $urandom_range(0, 8191),
                              $urandom_range(0, 16383));
                else send_word(ffbt_pkg::FUNC_ALLOC, $urandom_range(1, 400),
                               $urandom_range(0, 16383));
            end else if (a < 88 && live_blocks.size() > 0) begin
                send_word(ffbt_pkg::FUNC_FREE, $urandom_range(0, 8191),
                          live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end else begin
                send_word(ffbt_pkg::FUNC_FREE, $urandom_range(0, 8191),
                          $urandom_range(0, 16383));
            end
        end
        drain();
        $display("Covered zero, odd, oversize and random allocations, valid, repeated and");
        $display("bogus frees with merges, plus random stalls and a long output hold-off.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
